### hw/rtl/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg: shared definitions for the deferred release fifo
// operation codes, register indexes, reset values and sequencer states
// ----------------------------------------------------------------------------
package dfr_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REDUCE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_FLUSH  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_COUNT_LIMIT = 2'd0,
    REG_BYTE_LIMIT  = 2'd1,
    REG_BYPASS      = 2'd2,
    REG_POSTPONED   = 2'd3
  } cfg_reg_t;

  localparam int unsigned HANDLE_W = 64;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned CLIM_W   = 20;
  localparam int unsigned QCNT_W   = 6;
  localparam int unsigned CFG_W    = 32;

  localparam logic [CLIM_W-1:0] COUNT_LIMIT_RST = CLIM_W'(256 * 1024);
  localparam logic [SIZE_W-1:0] BYTE_LIMIT_RST  = SIZE_W'(32 * 1024 * 1024);

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [ID_W-1:0]     free_id;
    logic [SIZE_W-1:0]   size;
  } entry_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_READ  = 6'b001000,
    ST_POP   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage

### hw/rtl/deferred_release_fifo.sv
// ----------------------------------------------------------------------------
// deferred_release_fifo: quarantine fifo for buffers with deferred release
// queues (handle, method id, size) entries and releases the oldest under
// count and byte limits, on reduce, clear or flush requests
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   func, handle, free_id, byte_size,
//                                            reduce_count
//  out      output     out_valid / out_stall kind, handle, free_id, size,
//                                            status, pending, queued_count, last
//  cfg      input      cfg_we                cfg_index, cfg_data
//
//  in_stall is high from the accept of a transaction until the sequencer is
//  back in idle: execute, limit check and done, or execute and done when an
//  add is ignored, dropped or released at once, plus a limit check, store
//  read and release per released queue entry; the next one is taken in idle.
//  each cycle of out_stall on a pending result holds the emitting state.
//  rst_n is synchronous; the entry store itself is not cleared.
// ----------------------------------------------------------------------------
module deferred_release_fifo #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_func,
  input  logic [dfr_pkg::HANDLE_W-1:0]   in_handle,
  input  logic [dfr_pkg::ID_W-1:0]       in_free_id,
  input  logic [dfr_pkg::SIZE_W-1:0]     in_byte_size,
  input  logic [7:0]                     in_reduce_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_kind,
  output logic [dfr_pkg::HANDLE_W-1:0]   out_handle,
  output logic [dfr_pkg::ID_W-1:0]       out_free_id,
  output logic [dfr_pkg::SIZE_W-1:0]     out_size,
  output logic                           out_status,
  output logic                           out_pending,
  output logic [dfr_pkg::QCNT_W-1:0]     out_queued_count,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [dfr_pkg::CFG_W-1:0]      cfg_data
);
  import dfr_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned TW = SIZE_W + CW;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  state_t              state_r, state_nxt;
  func_t               op_func_r;
  entry_t              op_entry_r;
  logic [7:0]          rc_r, rc_nxt;
  logic                status_r, status_nxt;
  logic [IW-1:0]       head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [TW-1:0]       total_r, total_nxt;

  logic [CLIM_W-1:0]   count_limit_r;
  logic [SIZE_W-1:0]   byte_limit_r;
  logic                bypass_r, postponed_r;

  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  entry_t              out_entry_r, out_entry_nxt;
  logic                out_status_r, out_status_nxt;
  logic                out_pending_r, out_pending_nxt;
  logic [QCNT_W-1:0]   out_count_r, out_count_nxt;

  logic                accept, out_free, mem_we, full, over_limit, pop_want;
  logic                add_sub;
  logic [SIZE_W-1:0]   add_opnd;
  logic [TW-1:0]       total_sum;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (count_r == CW'(DEPTH));

  // shared byte-total adder: adds on queue, subtracts on release
  assign add_sub   = (state_r == ST_POP);
  assign add_opnd  = add_sub ? rd_data_r.size : op_entry_r.size;
  assign total_sum = total_r + (add_sub ? ~TW'(add_opnd) : TW'(add_opnd)) + TW'(add_sub);

  // shared limit compare
  assign over_limit = (CLIM_W'(count_r) > count_limit_r) || (total_r > TW'(byte_limit_r));

  always_comb begin
    unique case (op_func_r)
      FUNC_REDUCE: pop_want = (count_r != '0) && (rc_r != '0);
      FUNC_CLEAR:  pop_want = (count_r != '0);
      FUNC_ADD,
      FUNC_FLUSH:  pop_want = !postponed_r && (count_r != '0) && over_limit;
      default:     pop_want = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    rc_nxt          = rc_r;
    status_nxt      = status_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    total_nxt       = total_r;
    mem_we          = 1'b0;
    out_valid_nxt   = out_valid_r && out_stall;
    out_kind_nxt    = out_kind_r;
    out_entry_nxt   = out_entry_r;
    out_status_nxt  = out_status_r;
    out_pending_nxt = out_pending_r;
    out_count_nxt   = out_count_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rc_nxt     = in_reduce_count;
          status_nxt = 1'b0;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_func_r != FUNC_ADD) begin
          state_nxt = ST_CHECK;
        end else if (op_entry_r.handle == '0) begin
          state_nxt = ST_DONE;
        end else if ((!postponed_r && (count_limit_r == '0 || byte_limit_r == '0))
                     || bypass_r || (full && !postponed_r)) begin
          // release straight through without queuing
          if (out_free) begin
            out_valid_nxt   = 1'b1;
            out_kind_nxt    = 1'b0;
            out_entry_nxt   = op_entry_r;
            out_status_nxt  = 1'b0;
            out_pending_nxt = 1'b0;
            out_count_nxt   = '0;
            state_nxt       = ST_DONE;
          end
        end else if (full) begin
          status_nxt = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          mem_we    = 1'b1;
          tail_nxt  = (tail_r == IW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
          count_nxt = count_r + 1'b1;
          total_nxt = total_sum;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = pop_want ? ST_READ : ST_DONE;
      end
      ST_READ: begin
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = 1'b0;
          out_entry_nxt   = rd_data_r;
          out_status_nxt  = 1'b0;
          out_pending_nxt = 1'b0;
          out_count_nxt   = '0;
          head_nxt        = (head_r == IW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_nxt       = count_r - 1'b1;
          total_nxt       = total_sum;
          if (op_func_r == FUNC_REDUCE) begin
            rc_nxt = rc_r - 1'b1;
          end
          state_nxt = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = 1'b1;
          out_entry_nxt   = '0;
          out_status_nxt  = status_r;
          out_pending_nxt = (count_r != '0);
          out_count_nxt   = QCNT_W'(count_r);
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= op_entry_r;
    end
    if (state_r == ST_READ) begin
      rd_data_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_func_r         <= func_t'(in_func);
      op_entry_r.handle <= in_handle;
      op_entry_r.free_id <= in_free_id;
      op_entry_r.size   <= in_byte_size;
    end
    out_kind_r    <= out_kind_nxt;
    out_entry_r   <= out_entry_nxt;
    out_status_r  <= out_status_nxt;
    out_pending_r <= out_pending_nxt;
    out_count_r   <= out_count_nxt;
    rc_r          <= rc_nxt;
    status_r      <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
      total_r       <= '0;
      out_valid_r   <= 1'b0;
      count_limit_r <= COUNT_LIMIT_RST;
      byte_limit_r  <= BYTE_LIMIT_RST;
      bypass_r      <= 1'b0;
      postponed_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_COUNT_LIMIT: count_limit_r <= cfg_data[CLIM_W-1:0];
          REG_BYTE_LIMIT:  byte_limit_r  <= cfg_data[SIZE_W-1:0];
          REG_BYPASS:      bypass_r      <= cfg_data[0];
          REG_POSTPONED:   postponed_r   <= cfg_data[0];
          default:         ;
        endcase
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_handle       = out_entry_r.handle;
  assign out_free_id      = out_entry_r.free_id;
  assign out_size         = out_entry_r.size;
  assign out_status       = out_status_r;
  assign out_pending      = out_pending_r;
  assign out_queued_count = out_count_r;
  assign out_last         = out_kind_r;

endmodule
